// ===== rtl/two_edge_frequency_meter_defines.svh =====
// Assertion helpers used by the meter's controller RTL.
`ifndef TWO_EDGE_FREQUENCY_METER_DEFINES_SVH
`define TWO_EDGE_FREQUENCY_METER_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define TEFM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Cause in this cycle, effect in the next.
`define TEFM_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== rtl/tefm_pkg.sv =====
package tefm_pkg;

  localparam int CLK_HZ_W  = 27;
  localparam int TICK_W    = 32;
  localparam int PERIOD_W  = 32;

  localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RESET = CLK_HZ_W'(48000000);
  localparam logic [CLK_HZ_W-1:0] US_PER_SECOND  = CLK_HZ_W'(1000000);

  // Shared divider: one quotient bit per cycle over the 27-bit dividend.
  localparam int DIV_STEPS = CLK_HZ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Controller to datapath.
  typedef struct packed {
    logic take;        // sample beat accepted this cycle
    logic start_freq;  // start clock_hz / ticks
    logic load_freq;   // capture frequency quotient
    logic start_per;   // start 1e6 / frequency
    logic load_per;    // capture period quotient
  } tefm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stop_edge;   // rising edge on the pin while armed
    logic div_done;    // divider finished
  } tefm_status_t;

endpackage

// ===== rtl/two_edge_frequency_meter.sv =====
// Input-capture frequency meter. Each input beat is one tick of the counting
// clock carrying a sample of the measured pin. The first rising edge arms the
// meter and clears the tick counter; every later sample adds one tick (with
// wrap detection), and the next rising edge closes the measurement and yields
// one result beat: tick_total, frequency_hz = clock_hz / tick_total,
// period_us = 1000000 / frequency_hz (all ones when the frequency is zero),
// and overflowed when the counter wrapped. Samples are taken one per cycle
// while counting. The sample that closes a measurement stalls the input for
// two passes through one shared restoring divider at one quotient bit per
// cycle (27 steps each plus handoff), then until the result beat is taken.
// clock_hz resets to 48 MHz and is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the meter is idle; nothing enforces this.
module two_edge_frequency_meter (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [tefm_pkg::CLK_HZ_W-1:0]  cfg_wr_data,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pin_level,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tefm_pkg::TICK_W-1:0]    tick_total,
  output logic [tefm_pkg::CLK_HZ_W-1:0]  frequency_hz,
  output logic [tefm_pkg::PERIOD_W-1:0]  period_us,
  output logic                           overflowed
);
  import tefm_pkg::*;

  tefm_cmd_t    cmd;
  tefm_status_t status;

  // Sequencer: accept samples, run the two divisions, hold the result beat.
  tefm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Edge detect, tick counter, divider and result registers.
  tefm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .pin_level    (pin_level),
    .tick_total   (tick_total),
    .frequency_hz (frequency_hz),
    .period_us    (period_us),
    .overflowed   (overflowed)
  );

endmodule

// ===== rtl/tefm_divider.sv =====
module tefm_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tefm_pkg::CLK_HZ_W-1:0]  dividend,
  input  logic [tefm_pkg::TICK_W-1:0]    divisor,
  output logic [tefm_pkg::CLK_HZ_W-1:0]  quotient,
  output logic                           done
);
  import tefm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [TICK_W-1:0]    rem;
  logic [CLK_HZ_W-1:0]  quo;
  logic [TICK_W-1:0]    divr;

  logic [TICK_W:0] trial;
  logic [TICK_W:0] diff;
  logic            fits;

  // Restoring step: shift in next dividend bit, subtract if it fits.
  assign trial = {rem, quo[CLK_HZ_W-1]};
  assign diff  = trial - {1'b0, divr};
  assign fits  = ~diff[TICK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        rem      <= '0;
        quo      <= dividend;
        divr     <= divisor;
      end else if (busy) begin
        rem      <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
        quo      <= {quo[CLK_HZ_W-2:0], fits};
        step_cnt <= step_cnt - 1'b1;
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/tefm_datapath.sv =====
module tefm_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tefm_pkg::tefm_cmd_t            cmd,
  output tefm_pkg::tefm_status_t         status,
  input  logic                           cfg_wr_en,
  input  logic [tefm_pkg::CLK_HZ_W-1:0]  cfg_wr_data,
  input  logic                           pin_level,
  output logic [tefm_pkg::TICK_W-1:0]    tick_total,
  output logic [tefm_pkg::CLK_HZ_W-1:0]  frequency_hz,
  output logic [tefm_pkg::PERIOD_W-1:0]  period_us,
  output logic                           overflowed
);
  import tefm_pkg::*;

  logic [CLK_HZ_W-1:0] clock_hz;
  logic                last_level;
  logic                armed;
  logic [TICK_W-1:0]   tick_counter;
  logic                wrap_seen;

  logic [TICK_W-1:0]   res_ticks;
  logic [CLK_HZ_W-1:0] res_freq;
  logic [PERIOD_W-1:0] res_period;
  logic                res_ovf;

  logic                rising;
  logic [TICK_W-1:0]   count_inc;
  logic                div_start;
  logic [CLK_HZ_W-1:0] div_dividend;
  logic [TICK_W-1:0]   div_divisor;
  logic [CLK_HZ_W-1:0] div_quo;
  logic                div_done;

  assign rising    = pin_level & ~last_level;
  assign count_inc = tick_counter + 1'b1;

  assign status.stop_edge = armed & rising;
  assign status.div_done  = div_done;

  // One divider serves both quotients.
  assign div_start    = cmd.start_freq | cmd.start_per;
  assign div_dividend = cmd.start_per ? US_PER_SECOND : clock_hz;
  assign div_divisor  = cmd.start_per ? TICK_W'(res_freq) : res_ticks;

  tefm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz     <= CLOCK_HZ_RESET;
      last_level   <= 1'b0;
      armed        <= 1'b0;
      tick_counter <= '0;
      wrap_seen    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz <= cfg_wr_data;
      end
      if (cmd.take) begin
        last_level <= pin_level;
        if (!armed) begin
          if (rising) begin
            armed        <= 1'b1;
            tick_counter <= '0;
            wrap_seen    <= 1'b0;
          end
        end else begin
          tick_counter <= count_inc;
          if (rising) begin
            armed     <= 1'b0;
            wrap_seen <= 1'b0;
          end else if (count_inc == '0) begin
            wrap_seen <= 1'b1;
          end
        end
      end
    end
  end

  // Result registers: payload only, no reset.
  always_ff @(posedge clk) begin
    if (cmd.take && armed && rising) begin
      res_ticks <= count_inc;
      res_ovf   <= wrap_seen | (count_inc == '0);
    end
    if (cmd.load_freq) begin
      res_freq <= (res_ticks == '0) ? '0 : div_quo;
    end
    if (cmd.load_per) begin
      res_period <= (res_freq == '0) ? '1 : PERIOD_W'(div_quo);
    end
  end

  assign tick_total   = res_ticks;
  assign frequency_hz = res_freq;
  assign period_us    = res_period;
  assign overflowed   = res_ovf;

endmodule

// ===== rtl/tefm_ctrl.sv =====
`include "two_edge_frequency_meter_defines.svh"

module tefm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  tefm_pkg::tefm_status_t  status,
  output tefm_pkg::tefm_cmd_t     cmd
);
  import tefm_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_FREQ_GO,
    ST_FREQ_WAIT,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_SHOW
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.take       = (state == ST_RUN) && in_valid;
    cmd.start_freq = (state == ST_FREQ_GO);
    cmd.load_freq  = (state == ST_FREQ_WAIT) && status.div_done;
    cmd.start_per  = (state == ST_PER_GO);
    cmd.load_per   = (state == ST_PER_WAIT) && status.div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (cmd.take && status.stop_edge) begin
            state    <= ST_FREQ_GO;
            in_stall <= 1'b1;
          end
        end
        ST_FREQ_GO: begin
          state <= ST_FREQ_WAIT;
        end
        ST_FREQ_WAIT: begin
          if (status.div_done) begin
            state <= ST_PER_GO;
          end
        end
        ST_PER_GO: begin
          state <= ST_PER_WAIT;
        end
        ST_PER_WAIT: begin
          if (status.div_done) begin
            state     <= ST_SHOW;
            out_valid <= 1'b1;
          end
        end
        ST_SHOW: begin
          if (!out_stall) begin
            state     <= ST_RUN;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
          end
        end
        default: begin
          state     <= ST_RUN;
          out_valid <= 1'b0;
          in_stall  <= 1'b0;
        end
      endcase
    end
  end

  `TEFM_ASSERT(a_no_sample_while_result, !(out_valid && !in_stall), "sample open with result pending")
  `TEFM_ASSERT(a_stall_tracks_state, in_stall == (state != ST_RUN), "input stall out of step")
  `TEFM_ASSERT_NEXT(a_stop_starts_divide, cmd.take && status.stop_edge, state == ST_FREQ_GO, "stop edge lost")
  `TEFM_ASSERT(a_done_only_waiting, !status.div_done || state == ST_FREQ_WAIT || state == ST_PER_WAIT, "stray divider done")
  `TEFM_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && state == ST_SHOW, "result dropped")

endmodule
